// File: hdl/anf_pkg.sv
// ----------------------------------------------------------------------------
// anf_pkg: shared definitions for the ACK/NAK frame matcher
// Stage, status, operation and register index codes, the configuration
// struct and the attempt limit used by the register, tracker and top modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package anf_pkg;

   // Number of ended frame attempts after which the wait times out.
   localparam logic [7:0] MAX_ATTEMPTS = 8'd8;
   localparam logic [7:0] ATTEMPTS_SAT = 8'd255;

   // Operation codes of an input item.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_GAP   = 2'd2;

   // Result status codes.
   localparam logic [1:0] RES_WAIT    = 2'd0;
   localparam logic [1:0] RES_ACK     = 2'd1;
   localparam logic [1:0] RES_NAK     = 2'd2;
   localparam logic [1:0] RES_TIMEOUT = 2'd3;

   // Frame parser stages.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SYNC1 = 4'd1;
   localparam logic [3:0] ST_SYNC2 = 4'd2;
   localparam logic [3:0] ST_CLASS = 4'd3;
   localparam logic [3:0] ST_ID    = 4'd4;
   localparam logic [3:0] ST_LEN0  = 4'd5;
   localparam logic [3:0] ST_LEN1  = 4'd6;
   localparam logic [3:0] ST_PAY0  = 4'd7;
   localparam logic [3:0] ST_PAY1  = 4'd8;
   localparam logic [3:0] ST_CK0   = 4'd9;
   localparam logic [3:0] ST_CK1   = 4'd10;

   // Configuration register indexes.
   localparam logic [2:0] REG_EXPECTED_CLASS = 3'd0;
   localparam logic [2:0] REG_EXPECTED_ID    = 3'd1;
   localparam logic [2:0] REG_SYNC_FIRST     = 3'd2;
   localparam logic [2:0] REG_SYNC_SECOND    = 3'd3;
   localparam logic [2:0] REG_ACK_CLASS      = 3'd4;
   localparam logic [2:0] REG_ACK_MSG_ID     = 3'd5;
   localparam logic [2:0] REG_NAK_MSG_ID     = 3'd6;

   typedef struct packed {
      logic [7:0] expected_class;
      logic [7:0] expected_id;
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] ack_class;
      logic [7:0] ack_msg_id;
      logic [7:0] nak_msg_id;
   } cfg_type;

endpackage

`default_nettype wire

// File: hdl/anf_req_if.sv
// ----------------------------------------------------------------------------
// anf_req_if: input item channel
// Valid/ready channel carrying an operation code and a received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface anf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/anf_rsp_if.sv
// ----------------------------------------------------------------------------
// anf_rsp_if: result channel
// Valid/ready channel carrying the match status and the attempts used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface anf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] attempts_used;

   modport source (output valid, output status, output attempts_used, input ready);
   modport sink (input valid, input status, input attempts_used, output ready);
endinterface

`default_nettype wire

// File: hdl/anf_csr_if.sv
// ----------------------------------------------------------------------------
// anf_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface anf_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/anf_csr_regs.sv
// ----------------------------------------------------------------------------
// anf_csr_regs: configuration registers
// Holds the seven match registers and decodes writes by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module anf_csr_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [2:0]       wr_index,
   input  wire logic [7:0]       wr_data,
   output anf_pkg::cfg_type      cfg
);

   anf_pkg::cfg_type cfg_ff;
   anf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            anf_pkg::REG_EXPECTED_CLASS: cfg_in.expected_class = wr_data;
            anf_pkg::REG_EXPECTED_ID:    cfg_in.expected_id    = wr_data;
            anf_pkg::REG_SYNC_FIRST:     cfg_in.sync_first     = wr_data;
            anf_pkg::REG_SYNC_SECOND:    cfg_in.sync_second    = wr_data;
            anf_pkg::REG_ACK_CLASS:      cfg_in.ack_class      = wr_data;
            anf_pkg::REG_ACK_MSG_ID:     cfg_in.ack_msg_id     = wr_data;
            anf_pkg::REG_NAK_MSG_ID:     cfg_in.nak_msg_id     = wr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_class <= 8'd0;
         cfg_ff.expected_id    <= 8'd0;
         cfg_ff.sync_first     <= 8'd181;
         cfg_ff.sync_second    <= 8'd98;
         cfg_ff.ack_class      <= 8'd5;
         cfg_ff.ack_msg_id     <= 8'd1;
         cfg_ff.nak_msg_id     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/anf_tracker.sv
// ----------------------------------------------------------------------------
// anf_tracker: frame parser and attempt counter
// Steps the frame stage on each item and produces the item's status and
// the attempt count after the step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module anf_tracker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [1:0]       op,
   input  wire logic [7:0]       rx_byte,
   input  wire anf_pkg::cfg_type cfg,
   output logic [1:0]            status,
   output logic [7:0]            attempts
);

   logic [3:0] stage_ff, stage_in;
   logic [7:0] frame_class_ff, frame_class_in;
   logic [7:0] frame_msg_ff, frame_msg_in;
   logic [7:0] acked_class_ff, acked_class_in;
   logic [7:0] acked_msg_ff, acked_msg_in;
   logic [7:0] count_ff, count_in;

   // Outcome of ending an attempt, and of judging a complete frame.
   logic [7:0] count_bumped;
   logic       timed_out;
   logic [3:0] end_stage;
   logic [1:0] end_status;
   logic       payload_match;
   logic [3:0] judge_stage;
   logic [1:0] judge_status;
   logic [7:0] judge_count;

   always_comb begin
      count_bumped = (count_ff < anf_pkg::ATTEMPTS_SAT) ? count_ff + 8'd1 : count_ff;
      timed_out    = (count_bumped >= anf_pkg::MAX_ATTEMPTS);
      end_stage    = timed_out ? anf_pkg::ST_IDLE : anf_pkg::ST_SYNC1;
      end_status   = timed_out ? anf_pkg::RES_TIMEOUT : anf_pkg::RES_WAIT;

      payload_match = (acked_class_ff == cfg.expected_class) &&
                      (acked_msg_ff == cfg.expected_id);
      if (payload_match && frame_msg_ff == cfg.ack_msg_id) begin
         judge_stage  = anf_pkg::ST_IDLE;
         judge_status = anf_pkg::RES_ACK;
         judge_count  = count_ff;
      end else if (payload_match && frame_msg_ff == cfg.nak_msg_id) begin
         judge_stage  = anf_pkg::ST_IDLE;
         judge_status = anf_pkg::RES_NAK;
         judge_count  = count_ff;
      end else begin
         judge_stage  = end_stage;
         judge_status = end_status;
         judge_count  = count_bumped;
      end
   end

   always_comb begin
      stage_in       = stage_ff;
      frame_class_in = frame_class_ff;
      frame_msg_in   = frame_msg_ff;
      acked_class_in = acked_class_ff;
      acked_msg_in   = acked_msg_ff;
      count_in       = count_ff;
      status         = anf_pkg::RES_WAIT;

      case (op)
         anf_pkg::OP_START: begin
            stage_in       = anf_pkg::ST_SYNC1;
            frame_class_in = 8'd0;
            frame_msg_in   = 8'd0;
            acked_class_in = 8'd0;
            acked_msg_in   = 8'd0;
            count_in       = 8'd0;
         end
         anf_pkg::OP_BYTE: begin
            unique case (stage_ff)
               anf_pkg::ST_IDLE: stage_in = anf_pkg::ST_IDLE;
               anf_pkg::ST_SYNC1: begin
                  if (rx_byte == cfg.sync_first) stage_in = anf_pkg::ST_SYNC2;
               end
               anf_pkg::ST_SYNC2: begin
                  stage_in = (rx_byte == cfg.sync_second) ? anf_pkg::ST_CLASS
                                                          : anf_pkg::ST_SYNC1;
               end
               anf_pkg::ST_CLASS: begin
                  frame_class_in = rx_byte;
                  stage_in       = anf_pkg::ST_ID;
               end
               anf_pkg::ST_ID: begin
                  frame_msg_in = rx_byte;
                  stage_in     = anf_pkg::ST_LEN0;
               end
               anf_pkg::ST_LEN0: stage_in = anf_pkg::ST_LEN1;
               anf_pkg::ST_LEN1: begin
                  if (frame_class_ff != cfg.ack_class) begin
                     stage_in = end_stage;
                     status   = end_status;
                     count_in = count_bumped;
                  end else begin
                     stage_in = anf_pkg::ST_PAY0;
                  end
               end
               anf_pkg::ST_PAY0: begin
                  acked_class_in = rx_byte;
                  stage_in       = anf_pkg::ST_PAY1;
               end
               anf_pkg::ST_PAY1: begin
                  acked_msg_in = rx_byte;
                  stage_in     = anf_pkg::ST_CK0;
               end
               anf_pkg::ST_CK0: stage_in = anf_pkg::ST_CK1;
               anf_pkg::ST_CK1: begin
                  stage_in = judge_stage;
                  status   = judge_status;
                  count_in = judge_count;
               end
               default: stage_in = anf_pkg::ST_IDLE;
            endcase
         end
         anf_pkg::OP_GAP: begin
            unique case (stage_ff) inside
               anf_pkg::ST_IDLE: stage_in = anf_pkg::ST_IDLE;
               anf_pkg::ST_CK0, anf_pkg::ST_CK1: begin
                  stage_in = judge_stage;
                  status   = judge_status;
                  count_in = judge_count;
               end
               anf_pkg::ST_SYNC1, anf_pkg::ST_SYNC2, anf_pkg::ST_CLASS,
               anf_pkg::ST_ID, anf_pkg::ST_LEN0, anf_pkg::ST_LEN1,
               anf_pkg::ST_PAY0, anf_pkg::ST_PAY1: begin
                  stage_in = end_stage;
                  status   = end_status;
                  count_in = count_bumped;
               end
               default: stage_in = anf_pkg::ST_IDLE;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff       <= anf_pkg::ST_IDLE;
         frame_class_ff <= 8'd0;
         frame_msg_ff   <= 8'd0;
         acked_class_ff <= 8'd0;
         acked_msg_ff   <= 8'd0;
         count_ff       <= 8'd0;
      end else if (step_en) begin
         stage_ff       <= stage_in;
         frame_class_ff <= frame_class_in;
         frame_msg_ff   <= frame_msg_in;
         acked_class_ff <= acked_class_in;
         acked_msg_ff   <= acked_msg_in;
         count_ff       <= count_in;
      end
   end

   assign attempts = count_in;

endmodule

`default_nettype wire

// File: hdl/ack_nak_frame_matcher_top.sv
// ----------------------------------------------------------------------------
// ack_nak_frame_matcher_top: ACK/NAK frame matcher
// Watches received bytes for an acknowledge frame answering a command and
// reports ACK, NAK or timeout after a bounded number of frame attempts.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per transfer: a start, a received byte or a read
//   gap. Every accepted item yields exactly one transfer on rsp_ch with the
//   status (waiting, ack, nak or timed out) and the attempts used so far.
//   csr_ch writes the match registers (expected class and id, sync bytes,
//   acknowledge class and ids); it is always ready and should be used only
//   while no item is in flight.
//   An item is first held in the input register, then the frame parser steps
//   and the result register loads. Throughput is one item per cycle while
//   the result consumer does not stall; the parser stage updates its state
//   once for each item that advances.
//   When the result consumer stalls, the result register holds, the input
//   register fills and req_ch.ready drops only when both are occupied.
//   Synchronous reset empties both registers, idles the parser (bytes and
//   gaps are then ignored until a start) and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ack_nak_frame_matcher_top (
   input  wire logic  clock,
   input  wire logic  reset,
   anf_req_if.sink    req_ch,
   anf_rsp_if.source  rsp_ch,
   anf_csr_if.sink    csr_ch
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_op_ff;
   logic [7:0] in_byte_ff;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_status_ff;
   logic [7:0] out_attempts_ff;

   logic             advance;
   logic             req_take;
   anf_pkg::cfg_type cfg;
   logic [1:0]       step_status;
   logic [7:0]       step_attempts;

   // An item moves from the input register into the result register when the
   // result register is empty or is being drained in this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   anf_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   anf_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .op       (in_op_ff),
      .rx_byte  (in_byte_ff),
      .cfg      (cfg),
      .status   (step_status),
      .attempts (step_attempts)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load on their transfers and need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_ch.op;
         in_byte_ff <= req_ch.rx_byte;
      end
      if (advance) begin
         out_status_ff   <= step_status;
         out_attempts_ff <= step_attempts;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.attempts_used = out_attempts_ff;

endmodule

`default_nettype wire
